// ===== design/ctor_pkg.sv =====
// ----------------------------------------------------------------------------
// ctor_pkg
// Shared types and constants for the cookie table with oldest-slot replacement.
// ----------------------------------------------------------------------------
package ctor_pkg;

   localparam int COOKIE_W = 32;
   localparam int STAMP_W  = 31;
   localparam int SLOT_W   = 4;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   // one table slot as it sits in the store
   typedef struct packed {
      logic [COOKIE_W-1:0] cookie;
      logic [STAMP_W-1:0]  stamp;
   } ctor_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } ctor_state_type;

endpackage

// ===== design/ctor_store.sv =====
// ----------------------------------------------------------------------------
// ctor_store
// Slot memory with one registered read port, one write port and a valid bit
// per slot; a slot never written since reset reads as all zero.
// ----------------------------------------------------------------------------
module ctor_store
   import ctor_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     rd_addr,
   output ctor_entry_type       rd_data,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  ctor_entry_type       wr_data
);

   ctor_entry_type               mem [ENTRIES];
   ctor_entry_type               rd_word_ff;
   logic                         rd_valid_ff;
   logic [ENTRIES-1:0]           valid_ff;
   logic [ENTRIES-1:0]           valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== design/cookie_table_oldest_replace_core.sv =====
// ----------------------------------------------------------------------------
// cookie_table_oldest_replace_core
// Table of recent command cookies; adds replace the slot with the oldest stamp.
// ----------------------------------------------------------------------------
// An item with a nonzero cookie holds busy high while the sequencer
// walks the slot memory one slot a cycle through its single read
// port, feeding one stamp compare and one cookie compare; the result
// strobe comes in the first cycle with busy low again, and the next
// word can be taken at the end of that cycle. Items with cookie zero
// need no walk: busy stays low and the result strobes in the next cycle. Each
// result is on rsp_ for exactly one cycle under rsp_valid and must be captured
// then, as the block cannot be held off. All slots read as zero right after
// reset.
module cookie_table_oldest_replace_core
   import ctor_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic signed [COOKIE_W-1:0]  req_cookie,
   input  logic [STAMP_W-1:0]          req_now_seconds,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic                        rsp_wrote,
   output logic [SLOT_W-1:0]           rsp_written_slot
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   ctor_state_type        state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [COOKIE_W-1:0]   cookie_ff, cookie_in;
   logic [STAMP_W-1:0]    now_ff, now_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  issuing_ff, issuing_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [STAMP_W-1:0]    best_time_ff, best_time_in;
   logic [IDX_W-1:0]      best_slot_ff, best_slot_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_wrote_ff, rsp_wrote_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   ctor_entry_type        rd_entry;
   ctor_entry_type        wr_entry;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  accept;
   logic                  better;
   logic                  match;
   logic                  last;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   ctor_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx_ff),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // slot 0 seeds the running minimum; strict less-than keeps the lowest index
   assign better = (rd_idx_ff == '0) || (rd_entry.stamp < best_time_ff);
   assign match  = (rd_entry.cookie == cookie_ff);
   assign last   = rd_pend_ff && (rd_idx_ff == LAST_IDX);

   assign wr_en          = (state_ff == ST_SCAN) && last && (mode_ff == MODE_ADD);
   assign wr_addr        = better ? rd_idx_ff : best_slot_ff;
   assign wr_entry.cookie = cookie_ff;
   assign wr_entry.stamp  = now_ff;
   assign slot_ext       = {{SLOT_W{1'b0}}, wr_addr};

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cookie_in    = cookie_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      issuing_in   = issuing_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = idx_ff;
      best_time_in = best_time_ff;
      best_slot_in = best_slot_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_wrote_in = 1'b0;
      rsp_slot_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               cookie_in = req_cookie;
               now_in    = req_now_seconds;
               if (req_cookie == '0) begin
                  // null cookie: no walk, found only for a check
                  rsp_valid_in = 1'b1;
                  rsp_found_in = (req_mode == MODE_CHECK);
               end else begin
                  state_in   = ST_SCAN;
                  idx_in     = '0;
                  issuing_in = 1'b1;
                  hit_in     = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               rd_pend_in = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (rd_pend_ff) begin
               if (better) begin
                  best_time_in = rd_entry.stamp;
                  best_slot_in = rd_idx_ff;
               end
               hit_in = hit_ff || match;
            end
            if (last) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (mode_ff == MODE_ADD) begin
                  rsp_wrote_in = 1'b1;
                  rsp_slot_in  = slot_ext[SLOT_W-1:0];
               end else begin
                  rsp_found_in = hit_ff || match;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      cookie_ff    <= cookie_in;
      now_ff       <= now_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      best_time_ff <= best_time_in;
      best_slot_ff <= best_slot_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_wrote_ff <= rsp_wrote_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_wrote        = rsp_wrote_ff;
   assign rsp_written_slot = rsp_slot_ff;

   // an add never reports found, and a word without a write carries slot zero
   a_found_wrote_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_wrote))
      else $error("found and wrote both set");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_wrote) |-> (rsp_written_slot == '0))
      else $error("slot nonzero without a write");

   // a nonzero cookie always starts a walk
   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cookie != '0)) |=> (busy && !rsp_valid))
      else $error("walk did not start");

   // the memory is written only at the end of an add walk
   a_write_at_end: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (rsp_valid && rsp_wrote && !busy))
      else $error("write without matching result");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");

endmodule
